/* rtl/core/c2d_pkg.sv */
// Shared types and constants for the 3x3 same-size windowed sum core.
// Used by c2d_sum and conv2d_same_zero_pad_core; depends on nothing else.
package c2d_pkg;

  localparam int COEF_W      = 16;
  localparam int RES_W       = 36;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
  localparam int WIDTH_REG_W = 11;
  localparam int HGT_REG_W   = 16;
  localparam int COEF_REG_W  = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int KSIZE       = 3;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_COEF_TOP     = 3'd2,
    CFG_COEF_MIDDLE  = 3'd3,
    CFG_COEF_BOTTOM  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic run_last;
    logic frame_last;
  } res_flags_t;

endpackage

/* rtl/core/conv2d_same_zero_pad_core.sv */
// Top level of the 3x3 same-size windowed sum (correlation) with zero padding.
// Depends on c2d_pkg and c2d_sum.
//
// Samples arrive in raster order on the s_ channel; s_tuser set marks a drain
// tick that stands for a zero padding sample. Output row r-1 is produced while
// input row r arrives, so each frame of H rows is followed by one drain row of
// W ticks. The first item of a row produces nothing; every later item produces
// one result, and the last item of a row produces two (the right padding is
// known). m_tuser marks the last result of an input item, m_tlast the final
// result of a frame. Results of the top input row are not produced.
// Throughput: one item per clock while the receiver does not stall, except that an
// item producing two results makes a second pass through the window stage. A
// result is registered in the window stage, products, row sums and output
// register in turn. The two line stores form one memory of MAX_WIDTH entries,
// read when the item is accepted and written back by the window stage, with
// forwarding when consecutive items hit the same entry (width one).
// The cfg_ channel writes registers at any time; it must only be used while
// the block is idle. Reset clears position, window and pipeline state and
// restores register defaults; the line memory is not cleared. When the
// receiver stalls, results stay in the pipeline and s_tready drops once full.
module conv2d_same_zero_pad_core
  import c2d_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,  // sample_value
  input  logic                               s_tuser,  // op
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [OUT_TDATA_W-1:0]             m_tdata,  // result_value
  output logic                               m_tuser,  // run_last
  output logic                               m_tlast,  // frame_last
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [CFG_IDX_W-1:0]               cfg_index,
  input  logic [COEF_REG_W-1:0]              cfg_data
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W = ((CW > WIDTH_REG_W) ? CW : WIDTH_REG_W) + 1;
  localparam int SB    = SAMPLE_BITS;

  typedef logic signed [SB-1:0] smp_t;

  typedef struct packed {
    logic [CW-1:0] addr;
    smp_t          col2;
    logic          first;
    logic          second;
    logic          row_ge1;
    logic          row_ge2;
    logic          col_zero;
    logic          drain;
  } item_t;

  // Configuration registers
  logic [WIDTH_REG_W-1:0] image_width;
  logic [HGT_REG_W-1:0]   image_height;
  logic [COEF_REG_W-1:0]  coef_top_row;
  logic [COEF_REG_W-1:0]  coef_middle_row;
  logic [COEF_REG_W-1:0]  coef_bottom_row;

  // Position and window state
  logic [CW-1:0]        col_pos;
  logic [HGT_REG_W-1:0] row_pos;
  smp_t                 win [KSIZE][2];

  // Line memory: upper half is the row two above, lower half the row above.
  logic [2*SB-1:0] line_mem [MAX_WIDTH];
  logic [2*SB-1:0] rd_data;

  // Window stage
  item_t s1;
  logic  s1_valid;
  logic  s1_phase;
  logic  s1_fwd;
  smp_t  fwd_prev;
  smp_t  fwd_prev2;

  logic [CMP_W-1:0]     w_last;
  logic [HGT_REG_W-1:0] h_eff;
  logic                 at_last;
  logic                 drain_row;
  logic                 in_accept;
  smp_t                 prev_raw;
  smp_t                 prev2_raw;
  smp_t                 col   [KSIZE];
  smp_t                 we0   [KSIZE];
  smp_t                 we1   [KSIZE];
  logic                 s1_update;
  logic                 s1_leave;
  logic                 sum_in_valid;
  logic                 sum_in_ready;
  coef_t                sum_coef   [KSIZE][KSIZE];
  smp_t                 sum_sample [KSIZE][KSIZE];
  res_flags_t           sum_flags;
  logic [RES_W-1:0]     sum_value;
  res_flags_t           out_flags;
  logic [COEF_REG_W-1:0] coef_rows [KSIZE];

  // Configuration port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= WIDTH_REG_W'(1024);
      image_height    <= HGT_REG_W'(1);
      coef_top_row    <= '0;
      coef_middle_row <= '0;
      coef_bottom_row <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  image_width     <= cfg_data[WIDTH_REG_W-1:0];
        CFG_IMAGE_HEIGHT: image_height    <= cfg_data[HGT_REG_W-1:0];
        CFG_COEF_TOP:     coef_top_row    <= cfg_data;
        CFG_COEF_MIDDLE:  coef_middle_row <= cfg_data;
        CFG_COEF_BOTTOM:  coef_bottom_row <= cfg_data;
        default: ;
      endcase
    end
  end

  // Position decode for the incoming request
  always_comb begin
    if (image_width == '0) begin
      w_last = '0;
    end else if (CMP_W'(image_width) > CMP_W'(MAX_WIDTH)) begin
      w_last = CMP_W'(MAX_WIDTH - 1);
    end else begin
      w_last = CMP_W'(image_width) - CMP_W'(1);
    end
    h_eff     = (image_height == '0) ? HGT_REG_W'(1) : image_height;
    at_last   = CMP_W'(col_pos) >= w_last;
    drain_row = row_pos >= h_eff;
  end

  assign in_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (in_accept) begin
      if (at_last) begin
        col_pos <= '0;
        row_pos <= drain_row ? '0 : row_pos + HGT_REG_W'(1);
      end else begin
        col_pos <= col_pos + CW'(1);
      end
    end
  end

  // Memory: read on acceptance, written back once by the window stage.
  always_ff @(posedge clk) begin
    if (s1_update) begin
      line_mem[s1.addr] <= {prev_raw, s1.col2};
    end
    if (in_accept) begin
      rd_data <= line_mem[col_pos];
    end
  end

  // Window stage control
  assign s1_update    = s1_valid && !s1_phase && sum_in_ready;
  assign s1_leave     = s1_valid && sum_in_ready && (s1_phase || !(s1.first && s1.second));
  assign s_tready     = !s1_valid || s1_leave;
  assign sum_in_valid = s1_valid && (s1_phase || s1.first || s1.second);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_phase <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_leave) begin
        s1_valid <= 1'b0;
      end
      if (s1_leave) begin
        s1_phase <= 1'b0;
      end else if (s1_update && s1.first && s1.second) begin
        s1_phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1.addr     <= col_pos;
      s1.col2     <= (drain_row || s_tuser) ? '0 : smp_t'(s_tdata[SB-1:0]);
      s1.first    <= (row_pos != '0) && (col_pos != '0);
      s1.second   <= (row_pos != '0) && at_last;
      s1.row_ge1  <= row_pos != '0;
      s1.row_ge2  <= row_pos >= HGT_REG_W'(2);
      s1.col_zero <= col_pos == '0;
      s1.drain    <= drain_row;
      // A write-back in this cycle to the entry being read is not seen by
      // the memory read, so its data is passed on directly.
      s1_fwd      <= s1_update && (s1.addr == col_pos);
      fwd_prev2   <= prev_raw;
      fwd_prev    <= s1.col2;
    end
  end

  always_comb begin
    prev_raw  = s1_fwd ? fwd_prev  : smp_t'(rd_data[SB-1:0]);
    prev2_raw = s1_fwd ? fwd_prev2 : smp_t'(rd_data[2*SB-1:SB]);
    col[0]    = s1.row_ge2 ? prev2_raw : '0;
    col[1]    = s1.row_ge1 ? prev_raw  : '0;
    col[2]    = s1.col2;
    for (int k = 0; k < KSIZE; k++) begin
      we0[k] = s1.col_zero ? '0 : win[k][0];
      we1[k] = s1.col_zero ? '0 : win[k][1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < KSIZE; k++) begin
        win[k][0] <= '0;
        win[k][1] <= '0;
      end
    end else if (s1_update) begin
      for (int k = 0; k < KSIZE; k++) begin
        win[k][0] <= we1[k];
        win[k][1] <= col[k];
      end
    end
  end

  // Operand selection. The second pass of a last-column item sees the window
  // already shifted, with the right padding column as zero.
  always_comb begin
    coef_rows[0] = coef_top_row;
    coef_rows[1] = coef_middle_row;
    coef_rows[2] = coef_bottom_row;
    for (int k = 0; k < KSIZE; k++) begin
      for (int l = 0; l < KSIZE; l++) begin
        sum_coef[k][l] = coef_t'(coef_rows[k][COEF_W*l +: COEF_W]);
      end
      if (s1_phase) begin
        sum_sample[k][0] = win[k][0];
        sum_sample[k][1] = win[k][1];
        sum_sample[k][2] = '0;
      end else if (s1.first) begin
        sum_sample[k][0] = we0[k];
        sum_sample[k][1] = we1[k];
        sum_sample[k][2] = col[k];
      end else begin
        sum_sample[k][0] = we1[k];
        sum_sample[k][1] = col[k];
        sum_sample[k][2] = '0;
      end
    end
    if (!s1_phase && s1.first) begin
      sum_flags.run_last   = !s1.second;
      sum_flags.frame_last = 1'b0;
    end else begin
      sum_flags.run_last   = 1'b1;
      sum_flags.frame_last = s1.drain;
    end
  end

  c2d_sum #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_in_valid),
    .in_ready  (sum_in_ready),
    .in_coef   (sum_coef),
    .in_sample (sum_sample),
    .in_flags  (sum_flags),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (sum_value),
    .out_flags (out_flags)
  );

  assign m_tdata = OUT_TDATA_W'(sum_value);
  assign m_tuser = out_flags.run_last;
  assign m_tlast = out_flags.frame_last;

  // The second pass exists only for an item that produces two results.
  a_phase_pair : assert property (@(posedge clk) disable iff (rst)
    s1_phase |-> (s1_valid && s1.first && s1.second))
    else $error("second pass without a two-result item");

  // The second pass always follows the single write-back of its item.
  a_phase_after_write : assert property (@(posedge clk) disable iff (rst)
    $rose(s1_phase) |-> $past(s1_update))
    else $error("second pass entered without write-back");

  // The end of a frame is always the last result of its item.
  a_frame_is_run_end : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser)
    else $error("frame end not at the end of a run");

  // Forwarded data belongs to an item that follows in the same column.
  a_fwd_same_col : assert property (@(posedge clk) disable iff (rst)
    (in_accept && s1_update && (s1.addr == col_pos)) |=> (s1_fwd && s1.col_zero))
    else $error("forwarding outside a single-column row");

endmodule

/* rtl/core/c2d_sum.sv */
// Multiply and reduce pipeline for one 3x3 window: products, row sums, output register.
// Depends on c2d_pkg.
module c2d_sum
  import c2d_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  coef_t                         in_coef   [KSIZE][KSIZE],
  input  logic signed [SAMPLE_BITS-1:0] in_sample [KSIZE][KSIZE],
  input  res_flags_t                    in_flags,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic        [RES_W-1:0]       out_value,
  output res_flags_t                    out_flags
);

  localparam int PROD_W = COEF_W + SAMPLE_BITS;

  logic signed [PROD_W-1:0] prod [KSIZE][KSIZE];
  logic                     p_valid;
  res_flags_t               p_flags;
  logic signed [RES_W-1:0]  row_sum [KSIZE];
  logic                     r_valid;
  res_flags_t               r_flags;
  logic                     p_ready;
  logic                     r_ready;
  logic                     o_ready;

  // Each stage moves on when the one after it is empty or moving.
  assign o_ready  = !out_valid || out_ready;
  assign r_ready  = !r_valid || o_ready;
  assign p_ready  = !p_valid || r_ready;
  assign in_ready = p_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      r_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (p_ready) begin
        p_valid <= in_valid;
      end
      if (r_ready) begin
        r_valid <= p_valid;
      end
      if (o_ready) begin
        out_valid <= r_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready && in_valid) begin
      for (int k = 0; k < KSIZE; k++) begin
        for (int l = 0; l < KSIZE; l++) begin
          prod[k][l] <= in_coef[k][l] * in_sample[k][l];
        end
      end
      p_flags <= in_flags;
    end
    // The sum wraps at the result width, so products may be cut to it first.
    if (r_ready && p_valid) begin
      for (int k = 0; k < KSIZE; k++) begin
        row_sum[k] <= RES_W'(prod[k][0]) + RES_W'(prod[k][1]) + RES_W'(prod[k][2]);
      end
      r_flags <= p_flags;
    end
    if (o_ready && r_valid) begin
      out_value <= row_sum[0] + row_sum[1] + row_sum[2];
      out_flags <= r_flags;
    end
  end

endmodule

/* tb/sv/tb_conv2d_same_zero_pad_core.sv */
// Self-checking testbench for the 3x3 same-size windowed sum core.
// Depends on c2d_pkg and conv2d_same_zero_pad_core; predicts every result and
// checks it against the stream that leaves the block.
module tb_conv2d_same_zero_pad_core;
  import c2d_pkg::*;

  localparam int MAX_W        = 1024;
  localparam int SAMPLE_W     = 16;
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_DRAIN   = 1'b1;
  localparam int RESET_CYCLES = 11;
  localparam int RAND_ITEMS   = 1450;
  localparam int WIDE_AT      = 0;
  localparam int CALM_ITEMS   = 250;
  localparam int HOLD_AT      = 1100;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic [RES_W-1:0] value;
    logic             run_last;
    logic             frame_last;
  } window_sum_t;

  // Tracks frame position, window and line stores, and queues the sums that
  // each accepted request must produce.
  class window_sum_board;
    logic [WIDTH_REG_W-1:0]   width_reg;
    logic [HGT_REG_W-1:0]     height_reg;
    logic [COEF_REG_W-1:0]    coef_rows[KSIZE];
    logic signed [SAMPLE_W-1:0] line_prev[MAX_W];
    logic signed [SAMPLE_W-1:0] line_prev2[MAX_W];
    logic signed [SAMPLE_W-1:0] window[KSIZE][2];
    logic signed [SAMPLE_W-1:0] grid[KSIZE][KSIZE];
    int unsigned col_pos, row_pos;
    window_sum_t pending_sums[$];
    int unsigned errors, items_in, sums_seen, frames_done;

    function new();
      width_reg = 11'd1024;
      height_reg = 16'd1;
      foreach (coef_rows[k]) coef_rows[k] = '0;
      foreach (line_prev[i]) begin
        line_prev[i] = '0;
        line_prev2[i] = '0;
      end
      foreach (window[k, j]) window[k][j] = '0;
      col_pos = 0;
      row_pos = 0;
      errors = 0;
      items_in = 0;
      sums_seen = 0;
      frames_done = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [COEF_REG_W-1:0] data);
      case (idx)
        CFG_IMAGE_WIDTH:  width_reg = data[WIDTH_REG_W-1:0];
        CFG_IMAGE_HEIGHT: height_reg = data[HGT_REG_W-1:0];
        CFG_COEF_TOP:     coef_rows[0] = data;
        CFG_COEF_MIDDLE:  coef_rows[1] = data;
        CFG_COEF_BOTTOM:  coef_rows[2] = data;
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return 32'(width_reg);
    endfunction

    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      return 32'(height_reg);
    endfunction

    // Exact sum of the nine weighted samples, wrapped to the result width.
    function logic [RES_W-1:0] weigh_grid();
      logic signed [63:0] acc;
      logic signed [COEF_W-1:0] coef;
      acc = '0;
      for (int k = 0; k < KSIZE; k++) begin
        for (int l = 0; l < KSIZE; l++) begin
          coef = coef_rows[k][COEF_W*l +: COEF_W];
          acc = acc + coef * grid[k][l];
        end
      end
      return acc[RES_W-1:0];
    endfunction

    function void take_sample(logic op, logic [SAMPLE_W-1:0] raw);
      int unsigned w, h, c, r;
      logic drain_row, last_col;
      logic signed [SAMPLE_W-1:0] fresh[KSIZE];
      window_sum_t sum;
      w = eff_width();
      h = eff_height();
      c = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
      r = row_pos;
      drain_row = (r >= h);
      last_col = (c >= w - 1);
      if (c == 0) foreach (window[k, j]) window[k][j] = '0;
      fresh[0] = (r >= 2) ? line_prev2[c] : '0;
      fresh[1] = (r >= 1) ? line_prev[c] : '0;
      fresh[2] = (drain_row || op == OP_DRAIN) ? '0 : raw;
      if (r >= 1 && c >= 1) begin
        for (int k = 0; k < KSIZE; k++) begin
          grid[k][0] = window[k][0];
          grid[k][1] = window[k][1];
          grid[k][2] = fresh[k];
        end
        sum.value = weigh_grid();
        sum.run_last = !last_col;
        sum.frame_last = 1'b0;
        pending_sums.push_back(sum);
      end
      // The right padding is known, so the last column closes its own window.
      if (r >= 1 && last_col) begin
        for (int k = 0; k < KSIZE; k++) begin
          grid[k][0] = window[k][1];
          grid[k][1] = fresh[k];
          grid[k][2] = '0;
        end
        sum.value = weigh_grid();
        sum.run_last = 1'b1;
        sum.frame_last = drain_row;
        pending_sums.push_back(sum);
      end
      for (int k = 0; k < KSIZE; k++) begin
        window[k][0] = window[k][1];
        window[k][1] = fresh[k];
      end
      line_prev2[c] = line_prev[c];
      line_prev[c] = fresh[2];
      if (last_col) begin
        col_pos = 0;
        if (drain_row) begin
          row_pos = 0;
          frames_done++;
        end else begin
          row_pos = (r + 1) & 32'hFFFF;
        end
      end else begin
        col_pos = (c + 1) & 32'h3FFF;
      end
      items_in++;
    endfunction

    function void check_sum(logic [RES_W-1:0] value, logic run_last, logic frame_last);
      window_sum_t got, want;
      got.value = value;
      got.run_last = run_last;
      got.frame_last = frame_last;
      sums_seen++;
      if (pending_sums.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t: result %h run_last %b frame_last %b with nothing expected",
                   $time, value, run_last, frame_last);
        return;
      end
      want = pending_sums.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 20)
          $display("%0t: mismatch: expected %h/%b/%b, actual %h/%b/%b",
                   $time, want.value, want.run_last, want.frame_last,
                   got.value, got.run_last, got.frame_last);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [SAMPLE_W-1:0]    s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [COEF_REG_W-1:0]  cfg_data = '0;

  window_sum_board sb = new();
  bit calm = 1'b0;
  int unsigned reg_writes = 0;
  int unsigned cycle_count = 0;

  conv2d_same_zero_pad_core #(
    .MAX_WIDTH(MAX_W),
    .SAMPLE_BITS(SAMPLE_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_sum(m_tdata[RES_W-1:0], m_tuser, m_tlast);
  end

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_REG_W-1:0] rand_coef_row();
    logic [COEF_REG_W-1:0] row;
    for (int s = 0; s < KSIZE; s++) begin
      case ($urandom_range(0, 5))
        0: row[COEF_W*s +: COEF_W] = 16'h8000;
        1: row[COEF_W*s +: COEF_W] = 16'h7FFF;
        2: row[COEF_W*s +: COEF_W] = 16'h1000;
        3: row[COEF_W*s +: COEF_W] = 16'h0000;
        default: row[COEF_W*s +: COEF_W] = 16'($urandom);
      endcase
    end
    return row;
  endfunction

  // Mostly well-formed frames: samples in image rows, drain ticks in the
  // drain row, with a little of each in the wrong place.
  function automatic logic next_op();
    if (sb.row_pos >= sb.eff_height())
      return ($urandom_range(0, 11) != 0) ? OP_DRAIN : OP_SAMPLE;
    return ($urandom_range(0, 15) == 0) ? OP_DRAIN : OP_SAMPLE;
  endfunction

  task automatic send_item(logic op, logic [SAMPLE_W-1:0] value);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= value;
    do @(posedge clk); while (!s_tready);
    sb.take_sample(op, value);
  endtask

  task automatic idle_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic send_run(int unsigned count);
    repeat (count) begin
      idle_gap();
      send_item(next_op(), rand_sample());
    end
  endtask

  task automatic send_frames(int unsigned count);
    int unsigned target;
    target = sb.frames_done + count;
    while (sb.frames_done < target) begin
      idle_gap();
      send_item(next_op(), rand_sample());
    end
  endtask

  // Rows of the first input row produce nothing, so a quiet queue alone does
  // not mean the pipeline is empty.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [COEF_REG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Called at a frame start, so the width may grow.
  task automatic random_setup();
    logic [COEF_REG_W-1:0] word;
    word = COEF_REG_W'({$urandom, $urandom});
    case ($urandom_range(0, 7))
      0: word[WIDTH_REG_W-1:0] = '0;
      1: word[WIDTH_REG_W-1:0] = 11'd1;
      default: word[WIDTH_REG_W-1:0] = 11'($urandom_range(2, 14));
    endcase
    if ($urandom_range(0, 3) != 0) word[COEF_REG_W-1:WIDTH_REG_W] = '0;
    if ($urandom_range(0, 2) != 0) write_reg(CFG_IMAGE_WIDTH, word);
    word = COEF_REG_W'({$urandom, $urandom});
    word[HGT_REG_W-1:0] = 16'($urandom_range(0, 5));
    if ($urandom_range(0, 3) != 0) word[COEF_REG_W-1:HGT_REG_W] = '0;
    if ($urandom_range(0, 2) != 0) write_reg(CFG_IMAGE_HEIGHT, word);
    if ($urandom_range(0, 2) == 0) write_reg(CFG_COEF_TOP, rand_coef_row());
    if ($urandom_range(0, 2) == 0) write_reg(CFG_COEF_MIDDLE, rand_coef_row());
    if ($urandom_range(0, 2) == 0) write_reg(CFG_COEF_BOTTOM, rand_coef_row());
  endtask

  // Inside a frame the width never grows, so every line entry read was
  // written by an earlier row of the same frame.
  task automatic mid_frame_setup();
    write_reg(CFG_IMAGE_HEIGHT, 48'($urandom_range(0, 5)));
    if ($urandom_range(0, 1) != 0)
      write_reg(CFG_IMAGE_WIDTH, 48'($urandom_range(1, sb.eff_width())));
    if ($urandom_range(0, 1) != 0) write_reg(CFG_COEF_MIDDLE, rand_coef_row());
  endtask

  initial begin : result_side
    bit held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && sb.items_in >= HOLD_AT) begin
        // Long stall while the sender keeps going, so the block backs up.
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned rand_items, start;
    bit wide_done;
    rand_items = 0;
    wide_done = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extreme coefficients and samples, misplaced drain ticks and samples.
    write_reg(CFG_IMAGE_WIDTH, 48'd3);
    write_reg(CFG_IMAGE_HEIGHT, 48'd2);
    write_reg(CFG_COEF_TOP, {16'h1000, 16'h7FFF, 16'h8000});
    write_reg(CFG_COEF_MIDDLE, {16'h8000, 16'h8000, 16'h8000});
    write_reg(CFG_COEF_BOTTOM, {16'h7FFF, 16'h7FFF, 16'h7FFF});
    send_item(OP_SAMPLE, 16'h8000);
    send_item(OP_SAMPLE, 16'h7FFF);
    send_item(OP_DRAIN, 16'h1234);
    send_item(OP_SAMPLE, 16'h8000);
    send_item(OP_SAMPLE, 16'h8000);
    send_item(OP_SAMPLE, 16'hFFFF);
    send_item(OP_DRAIN, 16'h0000);
    send_item(OP_SAMPLE, 16'h7FFF);
    send_item(OP_DRAIN, 16'h0000);
    settle();

    // Zero width and zero height both act as one.
    write_reg(CFG_IMAGE_WIDTH, 48'd0);
    write_reg(CFG_IMAGE_HEIGHT, 48'd0);
    send_item(OP_SAMPLE, 16'h7FFF);
    send_item(OP_DRAIN, 16'h0000);
    settle();

    // Tallest height, then cut short inside row one: the row becomes the drain
    // row and the column beyond the new width counts as the last one.
    write_reg(CFG_IMAGE_WIDTH, 48'd2);
    write_reg(CFG_IMAGE_HEIGHT, 48'd65535);
    send_item(OP_SAMPLE, 16'h8000);
    send_item(OP_SAMPLE, 16'h7FFF);
    send_item(OP_SAMPLE, 16'h8000);
    settle();
    write_reg(CFG_IMAGE_HEIGHT, 48'd1);
    write_reg(CFG_IMAGE_WIDTH, 48'd1);
    send_item(OP_SAMPLE, 16'h7FFF);
    settle();

    while (rand_items < RAND_ITEMS) begin
      start = sb.items_in;
      if (!wide_done && rand_items >= WIDE_AT) begin
        // One row at the widest setting; an out-of-range width counts as the
        // maximum. The drain row then runs at a narrow width.
        wide_done = 1'b1;
        write_reg(CFG_IMAGE_WIDTH, 48'd2047);
        write_reg(CFG_IMAGE_HEIGHT, 48'd1);
        send_run(MAX_W);
        settle();
        write_reg(CFG_IMAGE_WIDTH, 48'($urandom_range(1, 16)));
        send_frames(1);
      end else begin
        random_setup();
        if ($urandom_range(0, 5) == 0) begin
          send_run($urandom_range(1, sb.eff_width() * sb.eff_height()));
          settle();
          mid_frame_setup();
        end
        send_frames($urandom_range(1, 3));
      end
      rand_items += sb.items_in - start;
      if (rand_items + CALM_ITEMS >= RAND_ITEMS) calm = 1'b1;
      settle();
    end

    $display("run covered %0d requests in %0d frames and %0d register writes,",
             sb.items_in, sb.frames_done, reg_writes);
    $display("with %0d window sums checked and %0d errors", sb.sums_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
